// File: hdl/mmh_pkg.sv
// shared types, constants and mixing functions for the byte hash
package mmh_pkg;

    localparam int DATA_W = 64;
    localparam int LEN_W = 32;
    localparam int TAIL_W = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic [DATA_W-1:0] MUL_CONST = 64'hc6a4_a793_5bd1_e995;
    localparam int MIX_SHIFT = 47;
    localparam logic [TAIL_W-1:0] TAIL_MASK = 3'h7;

    // register index within the apb map
    localparam logic SEED_INDEX = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic [LEN_W-1:0]  message_length;
        logic              first;
        logic              skip;
        logic              partial;
        logic              last;
    } mmh_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mmh_q_stat_t;

    function automatic logic [DATA_W-1:0] mix47(input logic [DATA_W-1:0] v);
        mix47 = v ^ (v >> MIX_SHIFT);
    endfunction

    function automatic logic [DATA_W-1:0] tail_keep(input logic [TAIL_W-1:0] tail);
        tail_keep = ~({DATA_W{1'b1}} << {tail, 3'b000});
    endfunction

endpackage

// File: hdl/mmh_msg_if.sv
// message word channel
interface mmh_msg_if;
    logic                         valid;
    logic                         ready;
    logic [mmh_pkg::DATA_W-1:0]   data_word;
    logic [mmh_pkg::LEN_W-1:0]    message_length;
    logic                         last_word;

    modport source (output valid, data_word, message_length, last_word, input ready);
    modport sink (input valid, data_word, message_length, last_word, output ready);
endinterface

// File: hdl/mmh_digest_if.sv
// hash result channel
interface mmh_digest_if;
    logic                         valid;
    logic                         ready;
    logic [mmh_pkg::DATA_W-1:0]   hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink (input valid, hash_value, output ready);
endinterface

// File: hdl/mmh_fifo.sv
// short queue of classified words between front and back
module mmh_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mmh_pkg::mmh_entry_t push_entry,
    input  logic                pop,
    output mmh_pkg::mmh_entry_t pop_entry,
    output mmh_pkg::mmh_q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mmh_pkg::mmh_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry = mem_reg[rd_ptr_reg];
    assign stat.full = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: hdl/mmh_front.sv
// front end: accepts words, tracks message position, masks the tail
module mmh_front (
    input  logic                 clk,
    input  logic                 rst_n,
    mmh_msg_if.sink              msg,
    input  mmh_pkg::mmh_q_stat_t q_stat,
    output logic                 push,
    output mmh_pkg::mmh_entry_t  push_entry
);

    logic                          inside_reg, inside_next;
    logic [mmh_pkg::TAIL_W-1:0]    tail_reg, tail_next;
    logic                          first;
    logic [mmh_pkg::TAIL_W-1:0]    tail_cur;
    logic                          partial;

    assign msg.ready = !q_stat.full;
    assign push = msg.valid && msg.ready;

    always_comb
    begin
        first = !inside_reg;
        tail_cur = first ? (msg.message_length[mmh_pkg::TAIL_W-1:0] & mmh_pkg::TAIL_MASK)
                         : tail_reg;
        partial = msg.last_word && (tail_cur != '0);

        push_entry.data_word = partial ? (msg.data_word & mmh_pkg::tail_keep(tail_cur))
                                       : msg.data_word;
        push_entry.message_length = msg.message_length;
        push_entry.first = first;
        push_entry.skip = first && (msg.message_length == '0);
        push_entry.partial = partial;
        push_entry.last = msg.last_word;

        inside_next = inside_reg;
        tail_next = tail_reg;
        if (push)
        begin
            inside_next = !msg.last_word;
            tail_next = msg.last_word ? '0 : tail_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            tail_reg <= '0;
        end
        else
        begin
            inside_reg <= inside_next;
            tail_reg <= tail_next;
        end
    end

endmodule

// File: hdl/mmh_mul.sv
// multiply by the hash constant modulo 2^64 with one 32x32 multiplier over three steps
module mmh_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mmh_pkg::DATA_W-1:0]  operand,
    output logic                        done,
    output logic [mmh_pkg::DATA_W-1:0]  product
);

    localparam int HALF_W = mmh_pkg::DATA_W / 2;
    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    logic                        active_reg, active_next;
    logic [1:0]                  step_reg, step_next;
    logic                        done_reg, done_next;
    logic [mmh_pkg::DATA_W-1:0]  a_reg, a_next;
    logic [mmh_pkg::DATA_W-1:0]  acc_reg, acc_next;
    logic [HALF_W-1:0]           opa;
    logic [HALF_W-1:0]           opb;
    logic [mmh_pkg::DATA_W-1:0]  pp;

    always_comb
    begin
        opa = (step_reg == STEP_HL) ? a_reg[mmh_pkg::DATA_W-1:HALF_W] : a_reg[HALF_W-1:0];
        opb = (step_reg == STEP_LH) ? mmh_pkg::MUL_CONST[mmh_pkg::DATA_W-1:HALF_W]
                                    : mmh_pkg::MUL_CONST[HALF_W-1:0];
        pp = {{HALF_W{1'b0}}, opa} * {{HALF_W{1'b0}}, opb};

        active_next = active_reg;
        step_next = step_reg;
        a_next = a_reg;
        acc_next = acc_reg;
        done_next = 1'b0;

        if (start)
        begin
            active_next = 1'b1;
            step_next = STEP_LL;
            a_next = operand;
        end
        else if (active_reg)
        begin
            if (step_reg == STEP_LL)
            begin
                acc_next = pp;
            end
            else
            begin
                acc_next = {acc_reg[mmh_pkg::DATA_W-1:HALF_W] + pp[HALF_W-1:0],
                            acc_reg[HALF_W-1:0]};
            end
            if (step_reg == STEP_HL)
            begin
                active_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg <= STEP_LL;
            done_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign product = acc_reg;

endmodule

// File: hdl/mmh_back.sv
// back end: sequences seeding, word folding and finalization on the shared multiplier
module mmh_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mmh_pkg::DATA_W-1:0]  seed,
    input  mmh_pkg::mmh_q_stat_t        q_stat,
    input  mmh_pkg::mmh_entry_t         pop_entry,
    output logic                        pop,
    mmh_digest_if.source                digest
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_INIT,
        S_K1,
        S_K2,
        S_H,
        S_FIN,
        S_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    mmh_pkg::mmh_entry_t         ent_reg, ent_next;
    logic [mmh_pkg::DATA_W-1:0]  h_reg, h_next;
    logic [mmh_pkg::DATA_W-1:0]  res_reg, res_next;
    logic                        ov_reg, ov_next;
    logic [mmh_pkg::DATA_W-1:0]  od_reg, od_next;

    logic                        mstart;
    logic [mmh_pkg::DATA_W-1:0]  mop;
    logic                        mdone;
    logic [mmh_pkg::DATA_W-1:0]  mprod;
    logic                        dispatch;
    logic [mmh_pkg::DATA_W-1:0]  hcur;

    mmh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mstart),
        .operand (mop),
        .done    (mdone),
        .product (mprod)
    );

    always_comb
    begin
        state_next = state_reg;
        ent_next = ent_reg;
        h_next = h_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        pop = 1'b0;
        mstart = 1'b0;
        mop = h_reg;
        dispatch = 1'b0;
        hcur = (state_reg == S_INIT) ? (seed ^ mprod) : h_reg;

        if (ov_reg && digest.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    ent_next = pop_entry;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (ent_reg.first)
                begin
                    mstart = 1'b1;
                    mop = {{(mmh_pkg::DATA_W - mmh_pkg::LEN_W){1'b0}}, ent_reg.message_length};
                    state_next = S_INIT;
                end
                else
                begin
                    dispatch = 1'b1;
                end
            end
            S_INIT:
            begin
                if (mdone)
                begin
                    h_next = hcur;
                    dispatch = 1'b1;
                end
            end
            S_K1:
            begin
                if (mdone)
                begin
                    mstart = 1'b1;
                    mop = mmh_pkg::mix47(mprod);
                    state_next = S_K2;
                end
            end
            S_K2:
            begin
                if (mdone)
                begin
                    mstart = 1'b1;
                    mop = h_reg ^ mprod;
                    state_next = S_H;
                end
            end
            S_H:
            begin
                if (mdone)
                begin
                    h_next = mprod;
                    if (ent_reg.last)
                    begin
                        mstart = 1'b1;
                        mop = mmh_pkg::mix47(mprod);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (mdone)
                begin
                    res_next = mmh_pkg::mix47(mprod);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || digest.ready)
                begin
                    ov_next = 1'b1;
                    od_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // data phase shared by first and later words
        if (dispatch)
        begin
            if (ent_reg.skip)
            begin
                if (ent_reg.last)
                begin
                    mstart = 1'b1;
                    mop = mmh_pkg::mix47(hcur);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            else if (ent_reg.partial)
            begin
                mstart = 1'b1;
                mop = hcur ^ ent_reg.data_word;
                state_next = S_H;
            end
            else
            begin
                mstart = 1'b1;
                mop = ent_reg.data_word;
                state_next = S_K1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            h_reg <= '0;
            ent_reg <= '0;
            res_reg <= '0;
            od_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            h_reg <= h_next;
            ent_reg <= ent_next;
            res_reg <= res_next;
            od_reg <= od_next;
        end
    end

    assign digest.valid = ov_reg;
    assign digest.hash_value = od_reg;

endmodule

// File: hdl/murmur64_byte_hash.sv
// top level: 64-bit byte hash with apb seed register
// each multiply by the hash constant runs on one shared 32x32 multiplier
// full words use K1, K2, H multiplies, partial last words H only; first seeds, last finalizes
// after the finalizing multiply the result is registered in res_reg, then in od_reg; one word in the back at a time
// the queue lets the front accept up to QUEUE_DEPTH words ahead of the back
// reset clears control state and the seed to zero; no clearing pass
module murmur64_byte_hash #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mmh_msg_if.sink                        msg,
    mmh_digest_if.source                   digest,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mmh_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mmh_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mmh_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [mmh_pkg::DATA_W-1:0]  seed_reg, seed_next;
    logic                        reg_index;
    mmh_pkg::mmh_q_stat_t        q_stat;
    mmh_pkg::mmh_entry_t         push_entry;
    mmh_pkg::mmh_entry_t         pop_entry;
    logic                        q_push;
    logic                        q_pop;

    assign pready = 1'b1;
    assign reg_index = paddr[mmh_pkg::APB_ADDR_W-1];

    always_comb
    begin
        seed_next = seed_reg;
        if (psel && penable && pwrite && pready && (reg_index == mmh_pkg::SEED_INDEX))
        begin
            seed_next = pwdata;
        end
        prdata = (reg_index == mmh_pkg::SEED_INDEX) ? seed_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    mmh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .q_stat     (q_stat),
        .push       (q_push),
        .push_entry (push_entry)
    );

    mmh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .stat       (q_stat)
    );

    mmh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .q_stat    (q_stat),
        .pop_entry (pop_entry),
        .pop       (q_pop),
        .digest    (digest)
    );

    // queue never popped when empty
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    // queue never pushed when full
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue pushed while full");

    // a result beat is withdrawn only after it was taken
    a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(digest.valid) |-> $past(digest.ready))
        else $error("result dropped before handshake");

endmodule
